// ===== rtl/acm_pkg.sv =====
// Shared types, constants and helper functions for the auto-ranging capacitance meter.
// Used by acm_ctrl, acm_dp, acm_checker and the top level; depends on nothing.
`timescale 1ns / 1ps
package acm_pkg;

  localparam int ADC_BITS_DEF = 10;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MVQ_W     = 16;
  localparam int MIND_W    = 12;
  localparam int LOWC_W    = 16;
  localparam int MAXA_W    = 4;

  localparam int Q_FRAC  = 8;
  localparam int RANGE_W = 2;
  localparam int TIME_W  = 10;
  localparam int CAP_W   = 24;
  localparam int ATT_W   = 4;
  localparam int STAT_W  = 2;
  localparam int K_W     = 16;
  localparam int NUM_W   = K_W + TIME_W;
  localparam int OUT_DATA_W = ((RANGE_W + TIME_W + CAP_W + ATT_W + 7) / 8) * 8;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  localparam logic [MVQ_W-1:0]  RST_MV_PER_COUNT = MVQ_W'(826);
  localparam logic [MIND_W-1:0] RST_MIN_DELTA    = MIND_W'(5);
  localparam logic [LOWC_W-1:0] RST_LOW_CAP      = LOWC_W'(10);
  localparam logic [MAXA_W-1:0] RST_MAX_ATTEMPTS = MAXA_W'(15);

  localparam logic [RANGE_W-1:0] RANGE_LOW  = RANGE_W'(0);
  localparam logic [RANGE_W-1:0] RANGE_MID  = RANGE_W'(1);
  localparam logic [RANGE_W-1:0] RANGE_HIGH = RANGE_W'(2);
  localparam logic [RANGE_W-1:0] RANGE_NONE = RANGE_W'(3);

  localparam logic [TIME_W-1:0] TIME_START = TIME_W'(16);
  localparam logic [TIME_W:0]   TIME_LIMIT = (TIME_W + 1)'(1000);

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MV_PER_COUNT = 2'd0,
    REG_MIN_DELTA    = 2'd1,
    REG_LOW_CAP      = 2'd2,
    REG_MAX_ATTEMPTS = 2'd3
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_AGAIN    = 2'd0,
    ST_IN_RANGE = 2'd1,
    ST_OVER     = 2'd2,
    ST_LOW      = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_START,
    S_MUL_END,
    S_MUL_K,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MUL_START,
    MUL_END,
    MUL_K
  } mul_sel_t;

  typedef struct packed {
    logic [MVQ_W-1:0]  mv_per_count_q8;
    logic [MIND_W-1:0] min_delta_mv;
    logic [LOWC_W-1:0] low_cap_pf;
    logic [MAXA_W-1:0] max_attempts;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_init;
    logic     div_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic over;
    logic div_done;
    logic out_free;
  } sts_t;

  // Current source constant in units that give pF from ms and mV.
  function automatic logic [K_W-1:0] k_of_range(input logic [RANGE_W-1:0] r);
    logic [K_W-1:0] k;
    case (r)
      RANGE_LOW:  k = K_W'(550);
      RANGE_MID:  k = K_W'(5500);
      RANGE_HIGH: k = K_W'(55000);
      default:    k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/acm_ctrl.sv =====
// Sequencing state machine of the capacitance meter: accepts items and steps the datapath.
// Depends on acm_pkg.
`timescale 1ns / 1ps
module acm_ctrl import acm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_kind,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_kind && sts.busy) ? S_MUL_START : S_EMIT;
        end
      end
      S_MUL_START: state_next = S_MUL_END;
      S_MUL_END:   state_next = S_MUL_K;
      S_MUL_K:     state_next = S_CHECK;
      S_CHECK:     state_next = sts.over ? S_EMIT : S_DIV;
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.mul_sel  = MUL_START;
    cmd.div_init = 1'b0;
    cmd.div_step = 1'b0;
    cmd.finish   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MUL_START: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_START;
      end
      S_MUL_END: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_END;
      end
      S_MUL_K: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_K;
      end
      S_CHECK: cmd.div_init = !sts.over;
      S_DIV:   cmd.div_step = !sts.div_done;
      S_EMIT:  cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/acm_dp.sv =====
// Datapath of the capacitance meter: conversion multiplier, restoring divider,
// range state and the output register. Depends on acm_pkg.
`timescale 1ns / 1ps
module acm_dp import acm_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  cmd_t                  cmd,
  input  logic                  in_kind,
  input  logic [ADC_BITS-1:0]   in_start,
  input  logic [ADC_BITS-1:0]   in_end,
  input  logic                  out_ready,
  output sts_t                  sts,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [STAT_W-1:0]     out_user
);

  localparam int MV_W    = ADC_BITS + MVQ_W - Q_FRAC;
  localparam int MUL_A_W = (ADC_BITS > K_W) ? ADC_BITS : K_W;
  localparam int PROD_W  = MUL_A_W + MVQ_W;
  localparam int REM_W   = MV_W + 1;

  logic                kind_q;
  logic [ADC_BITS-1:0] start_q;
  logic [ADC_BITS-1:0] end_q;
  logic [MV_W-1:0]     mv_s;
  logic [MV_W-1:0]     mv_e;
  logic [NUM_W-1:0]    num;
  logic signed [MV_W:0] delta;

  logic [REM_W-1:0]     rem;
  logic [NUM_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [RANGE_W-1:0] range_sel;
  logic [TIME_W-1:0]  interval_ms;
  logic [ATT_W-1:0]   attempt_count;
  logic               busy;

  logic [RANGE_W-1:0] range_sel_next;
  logic [TIME_W-1:0]  interval_ms_next;
  logic [ATT_W-1:0]   attempt_count_next;
  logic               busy_next;
  stat_t              res_status;
  logic [CAP_W-1:0]   res_cap;

  logic [MUL_A_W-1:0] mul_a;
  logic [MVQ_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;

  logic                 over;
  logic [REM_W-1:0]     rem_sh;
  logic [REM_W-1:0]     den;
  logic                 ge;
  logic [CAP_W-1:0]     cap_sat;

  always_comb begin
    mul_a = '0;
    mul_b = cfg.mv_per_count_q8;
    case (cmd.mul_sel)
      MUL_START: mul_a = MUL_A_W'(start_q);
      MUL_END:   mul_a = MUL_A_W'(end_q);
      MUL_K: begin
        mul_a = MUL_A_W'(k_of_range(range_sel));
        mul_b = MVQ_W'(interval_ms);
      end
      default: mul_a = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  assign over   = (delta <= $signed((MV_W + 1)'(cfg.min_delta_mv)));
  assign den    = REM_W'(delta[MV_W-1:0]);
  assign rem_sh = {rem[REM_W-2:0], quo[NUM_W-1]};
  assign ge     = (rem_sh >= den);

  assign cap_sat = (|quo[NUM_W-1:CAP_W]) ? CAP_MAX : quo[CAP_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= in_kind;
      start_q <= in_start;
      end_q   <= in_end;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_START: mv_s <= prod[ADC_BITS+MVQ_W-1:Q_FRAC];
        MUL_END:   mv_e <= prod[ADC_BITS+MVQ_W-1:Q_FRAC];
        MUL_K: begin
          num   <= prod[NUM_W-1:0];
          delta <= $signed({1'b0, mv_e}) - $signed({1'b0, mv_s});
        end
        default: ;
      endcase
    end
    if (cmd.div_init) begin
      rem     <= '0;
      quo     <= num;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? (rem_sh - den) : rem_sh;
      quo     <= {quo[NUM_W-2:0], ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_comb begin
    logic [ATT_W-1:0]  att_inc;
    logic [MAXA_W-1:0] limit;
    logic [TIME_W:0]   time_dbl;
    stat_t             cls;
    logic              stop;

    att_inc  = attempt_count + 1'b1;
    limit    = (cfg.max_attempts == '0) ? MAXA_W'(1) : cfg.max_attempts;
    time_dbl = {interval_ms, 1'b0};
    cls      = ST_OVER;
    stop     = 1'b0;

    range_sel_next     = range_sel;
    interval_ms_next   = interval_ms;
    attempt_count_next = attempt_count;
    busy_next          = busy;
    res_status         = ST_AGAIN;
    res_cap            = '0;

    if (!kind_q) begin
      range_sel_next     = RANGE_MID;
      interval_ms_next   = TIME_START;
      attempt_count_next = '0;
      busy_next          = 1'b1;
    end else if (busy) begin
      if (!over) begin
        res_cap = cap_sat;
        cls     = (cap_sat <= CAP_W'(cfg.low_cap_pf)) ? ST_LOW : ST_IN_RANGE;
      end
      attempt_count_next = att_inc;
      stop = (cls == ST_IN_RANGE) || (att_inc >= limit);
      if (!stop && cls == ST_OVER) begin
        if (range_sel < RANGE_HIGH) begin
          range_sel_next = range_sel + 1'b1;
        end else if (time_dbl < TIME_LIMIT) begin
          interval_ms_next = time_dbl[TIME_W-1:0];
        end else begin
          stop = 1'b1;
        end
      end else if (!stop && cls == ST_LOW) begin
        if (range_sel > RANGE_LOW) begin
          range_sel_next = range_sel - 1'b1;
        end else if ((interval_ms >> 1) > TIME_W'(1)) begin
          interval_ms_next = interval_ms >> 1;
        end else begin
          stop = 1'b1;
        end
      end
      if (stop) begin
        busy_next  = 1'b0;
        res_status = cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_sel     <= RANGE_MID;
      interval_ms   <= TIME_START;
      attempt_count <= '0;
      busy          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.finish) begin
        range_sel     <= range_sel_next;
        interval_ms   <= interval_ms_next;
        attempt_count <= attempt_count_next;
        busy          <= busy_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_user <= res_status;
      out_data <= OUT_DATA_W'({attempt_count_next, res_cap, interval_ms_next, range_sel_next});
    end
  end

  assign sts.busy     = busy;
  assign sts.over     = over;
  assign sts.div_done = (div_cnt == DIV_CNT_W'(NUM_W));
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/autorange_capacitance_meter.sv =====
// Top level of the auto-ranging capacitance meter: configuration registers,
// controller and datapath. Depends on acm_pkg, acm_ctrl and acm_dp.
// A start item or a sample outside a series passes from accept straight to the output step;
// an evaluated sample passes through 3 multiplies, the over-range check, the divider and
// the output step, skipping the divider when it reads over range. The output step waits for
// a free output register. Items go one at a time; the divider yields one quotient bit per cycle.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous, active high) returns the range to 5.5 uA, the time to 16 ms,
// clears the series and the output valid, and loads the register defaults.
`timescale 1ns / 1ps
module autorange_capacitance_meter import acm_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF,
  parameter int S_DATA_W = ((2 * ADC_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // start_count, end_count
  input  logic                  s_tuser,   // kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // current_range, charge_ms, cap_pf, attempt
  output logic [STAT_W-1:0]     m_tuser,   // status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mv_per_count_q8 <= RST_MV_PER_COUNT;
      cfg.min_delta_mv    <= RST_MIN_DELTA;
      cfg.low_cap_pf      <= RST_LOW_CAP;
      cfg.max_attempts    <= RST_MAX_ATTEMPTS;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MV_PER_COUNT: cfg.mv_per_count_q8 <= cfg_data[MVQ_W-1:0];
        REG_MIN_DELTA:    cfg.min_delta_mv    <= cfg_data[MIND_W-1:0];
        REG_LOW_CAP:      cfg.low_cap_pf      <= cfg_data[LOWC_W-1:0];
        REG_MAX_ATTEMPTS: cfg.max_attempts    <= cfg_data[MAXA_W-1:0];
        default: ;
      endcase
    end
  end

  acm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .sts      (sts),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  acm_dp #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_kind   (s_tuser),
    .in_start  (s_tdata[ADC_BITS-1:0]),
    .in_end    (s_tdata[2*ADC_BITS-1:ADC_BITS]),
    .out_ready (m_tready),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

// ===== rtl/acm_checker.sv =====
// Port-level checks on the result stream of the capacitance meter, bound to the top level.
// Depends on acm_pkg and autorange_capacitance_meter.
`timescale 1ns / 1ps
module acm_checker import acm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [STAT_W-1:0]     m_tuser
);

  localparam int CAP_LSB = RANGE_W + TIME_W;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_range_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[RANGE_W-1:0] != RANGE_NONE)
    else $error("unused current range reported");

  a_over_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_OVER |-> m_tdata[CAP_LSB+CAP_W-1:CAP_LSB] == '0)
    else $error("over-range result with nonzero capacitance");

  a_time_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[CAP_LSB-1:RANGE_W] != '0)
    else $error("zero charge time reported");

endmodule

bind autorange_capacitance_meter acm_checker u_acm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
